// ----- rtl/texture_column_address_gen_unit_macros.svh -----
// Assertion macros for the texture column address generator.
// Used by the controller and datapath; relies on clk_i and rst_ni in scope.
`ifndef TEXTURE_COLUMN_ADDRESS_GEN_UNIT_MACROS_SVH
`define TEXTURE_COLUMN_ADDRESS_GEN_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define TCAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define TCAG_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TCAG_ASSERT(lbl, prop, msg)
`define TCAG_ASSERT_NR(lbl, prop, msg)
`endif

`endif

// ----- rtl/tcag_pkg.sv -----
// Package for the texture column address generator: widths, word types,
// register indexes and controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package tcag_pkg;

  // Field widths
  localparam int unsigned ROW_W     = 11;
  localparam int unsigned SH_W      = 16;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned STRIDE_W  = 15;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned DIRS_W    = 2;
  localparam int unsigned SCR_W     = 12;
  localparam int unsigned BPP_W     = 4;
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SRC_W     = 24;
  localparam int unsigned DST_W     = 26;

  // Internal arithmetic widths
  localparam int unsigned STEP_W = 32;
  localparam int unsigned POS_W  = 40;
  localparam int unsigned QUOT_W = DIM_W + FRAC_BITS;
  localparam int unsigned V2_W   = 18;
  localparam int unsigned PROD_W = V2_W + STEP_W + 1;
  localparam int unsigned ROWT_W = POS_W - FRAC_BITS;

  // Parameter defaults
  localparam int unsigned DEF_MAX_SCREEN_ROWS = 2048;
  localparam int unsigned DEF_MAX_TEX_SIZE    = 1024;

  // Register reset values
  localparam logic [SCR_W-1:0]    RST_SCREEN_HEIGHT = SCR_W'(480);
  localparam logic [STRIDE_W-1:0] RST_DST_STRIDE    = STRIDE_W'(2560);
  localparam logic [BPP_W-1:0]    RST_DST_BPP       = BPP_W'(4);
  localparam logic [BPP_W-1:0]    RST_TEX_BPP       = BPP_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_HEIGHT = 2'd0,
    CFG_DST_STRIDE    = 2'd1,
    CFG_DST_BPP       = 2'd2,
    CFG_TEX_BPP       = 2'd3
  } cfg_idx_e;

  // Item kinds
  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [ROW_W-1:0]    first_row;
    logic [ROW_W-1:0]    last_row;
    logic [SH_W-1:0]     stripe_height;
    logic [FRAC_BITS-1:0] wall_hit_frac;
    logic                side;
    logic [DIRS_W-1:0]   dir_signs;
    logic [COL_W-1:0]    column;
    logic [DIM_W-1:0]    tex_width;
    logic [DIM_W-1:0]    tex_height;
    logic [STRIDE_W-1:0] tex_stride;
    logic [SEL_W-1:0]    tex_select;
  } in_word_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_offset;
    logic [DST_W-1:0] dst_offset;
    logic [SEL_W-1:0] tex_id;
    logic             last;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic col;
    logic div_start;
    logic step_load;
    logic mul;
    logic sat;
    logic row;
    logic pmul;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;
    logic sh_zero;
    logic div_busy;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/tcag_chan_if.sv -----
// Valid/ready channel carrying one word of a given type.
// Depends on nothing; the word type is set per instance.
`timescale 1ns / 1ps

interface tcag_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/texture_column_address_gen_unit.sv -----
// Texture column address generator, top level: controller plus datapath.
// Depends on tcag_pkg, tcag_chan_if, tcag_ctrl and tcag_dp.
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    tcag_pkg::in_word_t (begin or pixel)
//   out_o    out  valid/ready    tcag_pkg::out_word_t (one per pixel)
//   cfg      in   cfg_we_i       cfg_idx_i / cfg_data_i, write only
//
// A pixel word runs through row, multiply, sum and output register load before
// the next accept; a stalled output register holds it longer.
// A begin word waits on the 27-step divider for the texture
// step (one quotient bit a cycle); with a zero stripe height the divider is skipped.
// A pixel word with no active stripe is dropped and ready stays high.
// rst_ni clears control state and loads register defaults asynchronously.
`timescale 1ns / 1ps

module texture_column_address_gen_unit #(
  parameter int unsigned MAX_SCREEN_ROWS = tcag_pkg::DEF_MAX_SCREEN_ROWS,
  parameter int unsigned MAX_TEX_SIZE    = tcag_pkg::DEF_MAX_TEX_SIZE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcag_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tcag_pkg::CFG_W-1:0]     cfg_data_i,
  tcag_chan_if.sink                      in_i,
  tcag_chan_if.source                    out_o
);
  import tcag_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  in_word_t  in_word;
  out_word_t out_word;
  logic      in_ready;
  logic      out_valid;

  assign in_word = in_i.data;

  tcag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_word.kind),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcag_dp #(
    .MAX_SCREEN_ROWS (MAX_SCREEN_ROWS),
    .MAX_TEX_SIZE    (MAX_TEX_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_word),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_word)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_word;

endmodule

// ----- rtl/tcag_div.sv -----
// Restoring divider, one quotient bit per cycle, for the texture step.
// Depends on tcag_pkg.
`timescale 1ns / 1ps

module tcag_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tcag_pkg::QUOT_W-1:0]  dividend_i,
  input  logic [tcag_pkg::SH_W-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [tcag_pkg::QUOT_W-1:0]  quot_o
);
  import tcag_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [QUOT_W-1:0] dq_q, dq_d;
  logic [SH_W-1:0]   rem_q, rem_d;
  logic [SH_W-1:0]   dv_q, dv_d;
  logic [SH_W:0]     trial;
  logic [SH_W:0]     diff;
  logic              ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, dq_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, dv_q};
  assign ge    = (trial >= {1'b0, dv_q});

  always_comb begin
    cnt_d = cnt_q;
    dq_d  = dq_q;
    rem_d = rem_q;
    dv_d  = dv_q;
    if (start_i) begin
      cnt_d = CNT_W'(QUOT_W);
      dq_d  = dividend_i;
      rem_d = '0;
      dv_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      dq_d  = {dq_q[QUOT_W-2:0], ge};
      rem_d = ge ? diff[SH_W-1:0] : trial[SH_W-1:0];
    end
  end

  // Hold the iteration count under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = dq_q;

endmodule

// ----- rtl/tcag_dp.sv -----
// Datapath: configuration registers, stripe state, divider, multipliers,
// output register. Depends on tcag_pkg, tcag_div and the assertion macros.
`timescale 1ns / 1ps
`include "texture_column_address_gen_unit_macros.svh"

module tcag_dp #(
  parameter int unsigned MAX_SCREEN_ROWS = tcag_pkg::DEF_MAX_SCREEN_ROWS,
  parameter int unsigned MAX_TEX_SIZE    = tcag_pkg::DEF_MAX_TEX_SIZE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcag_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tcag_pkg::CFG_W-1:0]     cfg_data_i,
  input  tcag_pkg::in_word_t             in_data_i,
  input  tcag_pkg::dp_cmd_t              cmd_i,
  output tcag_pkg::dp_sts_t              sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tcag_pkg::out_word_t            out_data_o
);
  import tcag_pkg::*;

  localparam int unsigned RowLimit = MAX_SCREEN_ROWS - 1;
  localparam logic [ROW_W-1:0] ROW_CLAMP = ROW_W'(RowLimit);
  localparam logic [DIM_W-1:0] DIM_CLAMP = DIM_W'(MAX_TEX_SIZE);
  localparam logic [POS_W-1:0] POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [SRC_W-1:0] SRC_MAX   = '1;
  localparam logic [DST_W-1:0] DST_MAX   = '1;
  localparam int unsigned SP_W  = ROWT_W + STRIDE_W + 1;
  localparam int unsigned CT_W  = DIM_W + BPP_W;
  localparam int unsigned DP_W  = ROW_W + STRIDE_W;
  localparam int unsigned DC_W  = COL_W + BPP_W;
  localparam int unsigned CP_W  = FRAC_BITS + 1 + DIM_W;

  // Configuration registers
  logic [SCR_W-1:0]    scr_q;
  logic [STRIDE_W-1:0] dstride_q;
  logic [BPP_W-1:0]    dbpp_q;
  logic [BPP_W-1:0]    tbpp_q;

  // Stripe state
  logic                 active_q;
  logic [ROW_W-1:0]     pixel_row_q;
  logic [ROW_W-1:0]     end_row_q;
  logic [DIM_W-1:0]     held_height_q;
  logic [DIM_W-1:0]     width_q;
  logic [SH_W-1:0]      sh_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic                 side_q;
  logic [DIRS_W-1:0]    dirs_q;
  logic [STRIDE_W-1:0]  held_stride_q;
  logic [SEL_W-1:0]     held_tex_q;
  logic [COL_W-1:0]     held_col_q;
  logic [DIM_W-1:0]     texel_col_q;
  logic [STEP_W-1:0]    step_q;
  logic [POS_W-1:0]     pos_q;
  logic signed [V2_W-1:0]   v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ROWT_W-1:0]    row_q;
  logic signed [SP_W-1:0] src_prod_q;
  logic [CT_W-1:0]      col_term_q;
  logic [DP_W-1:0]      dst_prod_q;
  logic [DC_W-1:0]      dcol_q;
  logic                 out_valid_q;
  out_word_t            out_data_q;

  // Begin capture
  logic [ROW_W-1:0] start_c, stop_c;
  logic [DIM_W-1:0] w_c, h_c;

  assign start_c = (32'(in_data_i.first_row) > RowLimit) ? ROW_CLAMP
                                                         : in_data_i.first_row;
  assign stop_c  = (32'(in_data_i.last_row) > RowLimit) ? ROW_CLAMP
                                                        : in_data_i.last_row;
  assign w_c = (in_data_i.tex_width == '0) ? DIM_W'(1) :
               (32'(in_data_i.tex_width) > MAX_TEX_SIZE) ? DIM_CLAMP : in_data_i.tex_width;
  assign h_c = (in_data_i.tex_height == '0) ? DIM_W'(1) :
               (32'(in_data_i.tex_height) > MAX_TEX_SIZE) ? DIM_CLAMP : in_data_i.tex_height;

  // Texel column with mirror flip
  logic [FRAC_BITS:0]  inv_frac;
  logic [CP_W-1:0]     col_prod;
  logic [COL_W-1:0]    col_raw;
  logic [DIM_W-1:0]    w_m1, col_cl, col_d;
  logic                mirror;

  assign inv_frac = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_q};
  assign col_prod = CP_W'(inv_frac) * CP_W'(width_q);
  assign col_raw  = col_prod[CP_W-1:FRAC_BITS];
  assign w_m1     = width_q - DIM_W'(1);
  assign col_cl   = (col_raw > {1'b0, w_m1}) ? w_m1 : col_raw[DIM_W-1:0];
  assign mirror   = (!side_q && dirs_q[0]) || (side_q && dirs_q[1]);
  assign col_d    = mirror ? (w_m1 - col_cl) : col_cl;

  // Centred start offset: 2*start - screen_height + stripe_height
  logic signed [V2_W-1:0] v2_d;
  assign v2_d = $signed({{(V2_W-ROW_W-1){1'b0}}, pixel_row_q, 1'b0})
              - $signed({{(V2_W-SCR_W){1'b0}}, scr_q})
              + $signed({{(V2_W-SH_W){1'b0}}, sh_q});

  // Step divider
  logic              div_busy;
  logic [QUOT_W-1:0] quot;

  tcag_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({held_height_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (sh_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Start position product, then halve toward zero and saturate
  logic signed [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] half_sum, half;
  logic [POS_W-1:0]  pos_sat;
  logic              pos_ovf;

  assign prod_d   = PROD_W'(v2_q) * PROD_W'($signed({1'b0, step_q}));
  assign half_sum = prod_q + {{(PROD_W-1){1'b0}}, prod_q[PROD_W-1]};
  assign half     = {half_sum[PROD_W-1], half_sum[PROD_W-1:1]};
  assign pos_ovf  = (half[PROD_W-1:POS_W-1] != '0) && (half[PROD_W-1:POS_W-1] != '1);
  assign pos_sat  = !pos_ovf ? half[POS_W-1:0] : (half[PROD_W-1] ? POS_MIN : POS_MAX);

  // Texture row: truncate toward zero, clamp to height-1
  logic [ROWT_W-1:0] row_tz, row_lim, row_d;
  assign row_tz  = pos_q[POS_W-1:FRAC_BITS]
                 + ROWT_W'(pos_q[POS_W-1] && (pos_q[FRAC_BITS-1:0] != '0));
  assign row_lim = {{(ROWT_W-DIM_W){1'b0}}, held_height_q - DIM_W'(1)};
  assign row_d   = ($signed(row_tz) > $signed(row_lim)) ? row_lim : row_tz;

  // Offset products
  logic signed [SP_W-1:0] src_prod_d;
  assign src_prod_d = SP_W'($signed(row_q)) * SP_W'($signed({1'b0, held_stride_q}));

  // Offset sums with clamping
  logic [SP_W:0]    src_sum;
  logic [DP_W:0]    dst_sum;
  logic [SRC_W-1:0] src_cl;
  logic [DST_W-1:0] dst_cl;
  logic             is_last;

  assign src_sum = {src_prod_q[SP_W-1], src_prod_q} + (SP_W+1)'(col_term_q);
  assign src_cl  = src_sum[SP_W] ? '0 :
                   (src_sum[SP_W-1:0] > SP_W'(SRC_MAX)) ? SRC_MAX : src_sum[SRC_W-1:0];
  assign dst_sum = {1'b0, dst_prod_q} + (DP_W+1)'(dcol_q);
  assign dst_cl  = (dst_sum > (DP_W+1)'(DST_MAX)) ? DST_MAX : dst_sum[DST_W-1:0];
  assign is_last = (pixel_row_q == end_row_q);

  // Position advance, saturating at the top
  logic [POS_W:0]   pos_adv;
  logic [POS_W-1:0] pos_next;
  assign pos_adv  = {pos_q[POS_W-1], pos_q} + (POS_W+1)'(step_q);
  assign pos_next = (!pos_adv[POS_W] && pos_adv[POS_W-1]) ? POS_MAX : pos_adv[POS_W-1:0];

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // Control state: configuration, active flag, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_q       <= RST_SCREEN_HEIGHT;
      dstride_q   <= RST_DST_STRIDE;
      dbpp_q      <= RST_DST_BPP;
      tbpp_q      <= RST_TEX_BPP;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SCREEN_HEIGHT: scr_q     <= cfg_data_i[SCR_W-1:0];
          CFG_DST_STRIDE:    dstride_q <= cfg_data_i[STRIDE_W-1:0];
          CFG_DST_BPP:       dbpp_q    <= cfg_data_i[BPP_W-1:0];
          CFG_TEX_BPP:       tbpp_q    <= cfg_data_i[BPP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        active_q <= (start_c <= stop_c);
      end else if (cmd_i.emit && is_last) begin
        active_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pixel_row_q   <= start_c;
      end_row_q     <= stop_c;
      held_height_q <= h_c;
      width_q       <= w_c;
      sh_q          <= in_data_i.stripe_height;
      frac_q        <= in_data_i.wall_hit_frac;
      side_q        <= in_data_i.side;
      dirs_q        <= in_data_i.dir_signs;
      held_stride_q <= in_data_i.tex_stride;
      held_tex_q    <= in_data_i.tex_select;
      held_col_q    <= in_data_i.column;
    end
    if (cmd_i.col) begin
      texel_col_q <= col_d;
      v2_q        <= v2_d;
      if (sh_q == '0) begin
        step_q <= '1;
      end
    end
    if (cmd_i.step_load) begin
      step_q <= STEP_W'(quot);
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.sat) begin
      pos_q <= pos_sat;
    end
    if (cmd_i.row) begin
      row_q <= row_d;
    end
    if (cmd_i.pmul) begin
      src_prod_q <= src_prod_d;
      col_term_q <= CT_W'(texel_col_q) * CT_W'(tbpp_q);
      dst_prod_q <= DP_W'(pixel_row_q) * DP_W'(dstride_q);
      dcol_q     <= DC_W'(held_col_q) * DC_W'(dbpp_q);
    end
    if (cmd_i.emit) begin
      out_data_q.src_offset <= src_cl;
      out_data_q.dst_offset <= dst_cl;
      out_data_q.tex_id     <= held_tex_q;
      out_data_q.last       <= is_last;
      pos_q                 <= pos_next;
      if (!is_last) begin
        pixel_row_q <= pixel_row_q + ROW_W'(1);
      end
    end
  end

  assign sts_o.active   = active_q;
  assign sts_o.sh_zero  = (sh_q == '0);
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TCAG_ASSERT(a_emit_slot_free, cmd_i.emit |-> out_free, "output register full on emit")
  `TCAG_ASSERT(a_last_clears_active, cmd_i.emit && is_last |=> !active_q, "stripe still active")
  `TCAG_ASSERT(a_div_start_idle, cmd_i.div_start |-> !div_busy, "divider restarted while busy")

endmodule

// ----- rtl/tcag_ctrl.sv -----
// Controller: sequences begin and pixel words through the datapath.
// Depends on tcag_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "texture_column_address_gen_unit_macros.svh"

module tcag_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_ready_o,
  input  tcag_pkg::dp_sts_t sts_i,
  output tcag_pkg::dp_cmd_t cmd_o
);
  import tcag_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_COL  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_SAT  = 8'b0001_0000,
    S_ROW  = 8'b0010_0000,
    S_PMUL = 8'b0100_0000,
    S_POUT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_kind_i == KIND_BEGIN) begin
            cmd_o.capture = 1'b1;
            state_d       = S_COL;
          end else if (sts_i.active) begin
            state_d = S_ROW;
          end
        end
      end
      S_COL: begin
        cmd_o.col = 1'b1;
        if (sts_i.sh_zero) begin
          state_d = S_MUL;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.step_load = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = S_IDLE;
      end
      S_ROW: begin
        cmd_o.row = 1'b1;
        state_d   = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.pmul = 1'b1;
        state_d    = S_POUT;
      end
      S_POUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TCAG_ASSERT_NR(a_reset_idle, !rst_ni |=> state_q == S_IDLE, "controller not idle in reset")
  `TCAG_ASSERT(a_begin_to_col, in_fire && in_kind_i == KIND_BEGIN |=> state_q == S_COL, "begin lost")
  `TCAG_ASSERT(a_div_exit, state_q == S_DIV && !sts_i.div_busy |=> state_q == S_MUL, "quotient lost")
  `TCAG_ASSERT(a_emit_to_idle, cmd_o.emit |=> state_q == S_IDLE, "controller not idle after emit")

endmodule
